// ===== rtl/out_of_range_event_monitor_defines.svh =====
// Assertion macros used by the checker file of the out-of-range monitor.
`ifndef OUT_OF_RANGE_EVENT_MONITOR_DEFINES_SVH
`define OUT_OF_RANGE_EVENT_MONITOR_DEFINES_SVH

// Property checked on every edge outside reset; uses clk and rst of the caller.
`define OREM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("out_of_range_event_monitor assertion failed");

// Property checked on every edge, reset included.
`define OREM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("out_of_range_event_monitor reset assertion failed");

`endif

// ===== rtl/orem_pkg.sv =====
// Types and constants shared by the out-of-range event monitor.
package orem_pkg;

  localparam int OBJECTS   = 4;
  localparam int OBJ_W     = 2;
  localparam int OBJ_CNT_W = OBJ_W + 1;
  localparam int VAL_W     = 32;
  localparam int DB_W      = 31;
  localparam int DLY_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  // compare width: value plus deadband never wraps
  localparam int CMP_W     = VAL_W + 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HI_LIM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LO_LIM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EVT_EN   = 3'd5;

  // Limit enable and event enable bit positions
  localparam int LE_LOW_BIT       = 0;
  localparam int LE_HIGH_BIT      = 1;
  localparam int EE_OFFNORMAL_BIT = 0;
  localparam int EE_NORMAL_BIT    = 2;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_HIGH   = 2'd1,
    ST_LOW    = 2'd2
  } evt_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] hi_lim;
    logic signed [VAL_W-1:0] lo_lim;
    logic [DB_W-1:0]         deadband;
    logic [DLY_W-1:0]        delay_ticks;
    logic [1:0]              lim_en;
    logic [2:0]              evt_en;
  } cfg_t;

  // Per-object state write-back
  typedef struct packed {
    logic             we;
    logic [OBJ_W-1:0] idx;
    logic [1:0]       state;
    logic [DLY_W-1:0] delay;
  } upd_t;

  typedef struct packed {
    logic [OBJ_W-1:0]        object_echo;
    logic                    transition;
    logic [1:0]              from_state;
    logic [1:0]              to_state;
    logic signed [VAL_W-1:0] exceeded_limit;
    logic                    in_alarm;
  } result_t;

endpackage

// ===== rtl/orem_regs.sv =====
// Configuration register file of the out-of-range event monitor.
module orem_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [orem_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [orem_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  output orem_pkg::cfg_t                      cfg,
  output logic                                reload
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        orem_pkg::REG_HI_LIM:   cfg.hi_lim      <= cfg_wdata;
        orem_pkg::REG_LO_LIM:   cfg.lo_lim      <= cfg_wdata;
        orem_pkg::REG_DEADBAND: cfg.deadband    <= cfg_wdata[orem_pkg::DB_W-1:0];
        orem_pkg::REG_DELAY:    cfg.delay_ticks <= cfg_wdata[orem_pkg::DLY_W-1:0];
        orem_pkg::REG_LIM_EN:   cfg.lim_en      <= cfg_wdata[1:0];
        orem_pkg::REG_EVT_EN:   cfg.evt_en      <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Countdowns reload from the write data in the same edge as the register
  assign reload = cfg_wr_en && (cfg_addr == orem_pkg::REG_DELAY);

endmodule

// ===== rtl/orem_state.sv =====
// Per-object event state and delay countdown store.
module orem_state (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              reload,
  input  logic [orem_pkg::DLY_W-1:0]        reload_val,
  input  orem_pkg::upd_t                    upd,
  input  logic [orem_pkg::OBJ_W-1:0]        rd_idx,
  output logic [1:0]                        rd_state,
  output logic [orem_pkg::DLY_W-1:0]        rd_delay
);

  logic [1:0]                 evt [orem_pkg::OBJECTS];
  logic [orem_pkg::DLY_W-1:0] dly [orem_pkg::OBJECTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < orem_pkg::OBJECTS; i++) begin
        evt[i] <= orem_pkg::ST_NORMAL;
        dly[i] <= '0;
      end
    end else if (reload) begin
      for (int i = 0; i < orem_pkg::OBJECTS; i++) begin
        dly[i] <= reload_val;
      end
    end else if (upd.we) begin
      evt[upd.idx] <= upd.state;
      dly[upd.idx] <= upd.delay;
    end
  end

  assign rd_state = evt[rd_idx];
  assign rd_delay = dly[rd_idx];

endmodule

// ===== rtl/orem_eval.sv =====
// Limit checks and event state transition for one tick.
module orem_eval (
  input  orem_pkg::cfg_t                        cfg,
  input  logic [orem_pkg::OBJ_W-1:0]            obj,
  input  logic signed [orem_pkg::VAL_W-1:0]     pv,
  input  logic [1:0]                            from,
  input  logic [orem_pkg::DLY_W-1:0]            delay,
  output orem_pkg::upd_t                        upd,
  output orem_pkg::result_t                     res
);

  logic                                in_range;
  logic                                active;
  logic                                cond;
  logic [1:0]                          target;
  logic [1:0]                          to;
  logic signed [orem_pkg::CMP_W-1:0]   pv_x;
  logic signed [orem_pkg::CMP_W-1:0]   hi_x;
  logic signed [orem_pkg::CMP_W-1:0]   lo_x;
  logic signed [orem_pkg::CMP_W-1:0]   db_x;
  logic signed [orem_pkg::CMP_W-1:0]   pv_db;
  logic signed [orem_pkg::CMP_W-1:0]   lo_db;
  logic                                hi_en;
  logic                                lo_en;
  logic                                off_en;
  logic                                norm_en;

  assign in_range = {1'b0, obj} < orem_pkg::OBJ_CNT_W'(orem_pkg::OBJECTS);

  assign pv_x  = orem_pkg::CMP_W'(pv);
  assign hi_x  = orem_pkg::CMP_W'(cfg.hi_lim);
  assign lo_x  = orem_pkg::CMP_W'(cfg.lo_lim);
  assign db_x  = signed'({3'b000, cfg.deadband});
  // pv < hi - db is checked as pv + db < hi; no wrap in the wider range
  assign pv_db = pv_x + db_x;
  assign lo_db = lo_x + db_x;

  assign hi_en   = cfg.lim_en[orem_pkg::LE_HIGH_BIT];
  assign lo_en   = cfg.lim_en[orem_pkg::LE_LOW_BIT];
  assign off_en  = cfg.evt_en[orem_pkg::EE_OFFNORMAL_BIT];
  assign norm_en = cfg.evt_en[orem_pkg::EE_NORMAL_BIT];

  always_comb begin
    active = (cfg.lim_en != 2'b00);
    cond   = 1'b0;
    target = orem_pkg::ST_NORMAL;
    case (from)
      orem_pkg::ST_NORMAL: begin
        if (pv_x > hi_x && hi_en && off_en) begin
          cond   = 1'b1;
          target = orem_pkg::ST_HIGH;
        end else if (pv_x < lo_x && lo_en && off_en) begin
          cond   = 1'b1;
          target = orem_pkg::ST_LOW;
        end
      end
      orem_pkg::ST_HIGH: cond = (pv_db < hi_x) && hi_en && norm_en;
      orem_pkg::ST_LOW:  cond = (pv_x > lo_db) && lo_en && norm_en;
      default: active = 1'b0;  // unused code: tick ignored
    endcase
  end

  always_comb begin
    upd.we    = in_range && active;
    upd.idx   = obj;
    upd.state = from;
    upd.delay = delay;
    if (cond) begin
      if (delay == '0) begin
        upd.state = target;
      end else begin
        upd.delay = delay - orem_pkg::DLY_W'(1);
      end
    end else begin
      upd.delay = cfg.delay_ticks;
    end
  end

  assign to = upd.we ? upd.state : from;

  always_comb begin
    res = '0;
    res.object_echo = obj;
    if (in_range) begin
      res.from_state = from;
      res.to_state   = to;
      res.transition = (from != to);
      res.in_alarm   = (to != orem_pkg::ST_NORMAL);
      if (from != to) begin
        if (to == orem_pkg::ST_HIGH || from == orem_pkg::ST_HIGH) begin
          res.exceeded_limit = cfg.hi_lim;
        end else begin
          res.exceeded_limit = cfg.lo_lim;
        end
      end
    end
  end

endmodule

// ===== rtl/out_of_range_event_monitor.sv =====
// Top level of the out-of-range event monitor.
// Usage:
//   Input channel (in_valid/in_ready) takes one beat per evaluation tick:
//   object_number and sample_value. Output channel (out_valid/out_ready)
//   returns one beat per tick with the old and new event state, the
//   transition flag, the limit involved and the in-alarm flag.
//   Configuration is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata):
//   0 high limit, 1 low limit, 2 deadband, 3 time delay (also reloads every
//   countdown), 4 limit enable, 5 event enable; write only while idle.
//   Throughput: one beat per cycle while out_ready stays high; the input
//   register feeds the state read-modify-write and compare logic, which
//   loads the output register.
//   Ticks for the same object may follow back to back, since the state
//   store is written at the edge where the result register loads.
//   Stall: while out_ready is low the output beat holds; the input register
//   still takes one more beat, after which in_ready drops.
//   Reset: rst (synchronous) clears the configuration registers, all objects
//   to normal with zero countdowns, and empties both pipeline stages.
module out_of_range_event_monitor (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [orem_pkg::OBJ_W-1:0]            object_number,
  input  logic signed [orem_pkg::VAL_W-1:0]     sample_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [orem_pkg::OBJ_W-1:0]            object_echo,
  output logic                                  transition,
  output logic [1:0]                            from_state,
  output logic [1:0]                            to_state,
  output logic signed [orem_pkg::VAL_W-1:0]     exceeded_limit,
  output logic                                  in_alarm,
  input  logic                                  cfg_wr_en,
  input  logic [orem_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [orem_pkg::CFG_DAT_W-1:0]        cfg_wdata
);

  orem_pkg::cfg_t                     cfg;
  logic                               reload;
  orem_pkg::upd_t                     upd_raw;
  orem_pkg::upd_t                     upd;
  orem_pkg::result_t                  res;
  orem_pkg::result_t                  res_q;
  logic [1:0]                         rd_state;
  logic [orem_pkg::DLY_W-1:0]         rd_delay;

  logic                               s1_valid;
  logic [orem_pkg::OBJ_W-1:0]         s1_obj;
  logic signed [orem_pkg::VAL_W-1:0]  s1_pv;
  logic                               out_load;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  orem_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .reload    (reload)
  );

  orem_state u_state (
    .clk        (clk),
    .rst        (rst),
    .reload     (reload),
    .reload_val (cfg_wdata[orem_pkg::DLY_W-1:0]),
    .upd        (upd),
    .rd_idx     (s1_obj),
    .rd_state   (rd_state),
    .rd_delay   (rd_delay)
  );

  orem_eval u_eval (
    .cfg   (cfg),
    .obj   (s1_obj),
    .pv    (s1_pv),
    .from  (rd_state),
    .delay (rd_delay),
    .upd   (upd_raw),
    .res   (res)
  );

  // State commits only when the beat moves into the output register
  always_comb begin
    upd    = upd_raw;
    upd.we = upd_raw.we && out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_obj <= object_number;
      s1_pv  <= sample_value;
    end
    if (out_load) begin
      res_q <= res;
    end
  end

  assign object_echo    = res_q.object_echo;
  assign transition     = res_q.transition;
  assign from_state     = res_q.from_state;
  assign to_state       = res_q.to_state;
  assign exceeded_limit = res_q.exceeded_limit;
  assign in_alarm       = res_q.in_alarm;

endmodule

// ===== rtl/orem_checker.sv =====
// Port-level assertions for the out-of-range event monitor, bound to the top.
`include "out_of_range_event_monitor_defines.svh"

module orem_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  transition,
  input logic [1:0]                            from_state,
  input logic [1:0]                            to_state,
  input logic signed [orem_pkg::VAL_W-1:0]     exceeded_limit,
  input logic                                  in_alarm
);

  `OREM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

  `OREM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(exceeded_limit))

  `OREM_ASSERT(a_state_hold, out_valid && !out_ready |=> $stable(to_state))

  `OREM_ASSERT(a_transition_flag, out_valid |-> transition == (from_state != to_state))

  `OREM_ASSERT(a_limit_zero, out_valid && !transition |-> exceeded_limit == '0)

  `OREM_ASSERT(a_alarm_flag, out_valid |-> in_alarm == (to_state != orem_pkg::ST_NORMAL))

endmodule

bind out_of_range_event_monitor orem_checker u_orem_checker (.*);
